// ===== rtl/ppp_pkg.sv =====
// Shared types, constants and register codes of the perspective point projection block.
package ppp_pkg;

    localparam int DATA_W          = 32;
    localparam int COEFF_COUNT     = 16;
    localparam int COEFF_IDX_W     = $clog2(COEFF_COUNT);
    localparam int FRAC_BITS       = 16;
    localparam int CLIP_ROWS       = 3;
    localparam int CLIP_W          = 2 * DATA_W - FRAC_BITS + 2;
    localparam int NDC_LIMIT_SHIFT = 40;
    localparam int Q_W             = NDC_LIMIT_SHIFT;
    localparam int INT_W           = Q_W - FRAC_BITS;
    localparam int NDC_W           = Q_W + 2;
    localparam int DIM_W           = 14;
    localparam int K_W             = DIM_W + 1;
    localparam int PROD_W          = NDC_W + K_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W          = 3;
    localparam int REG_IDX_W       = ADDR_W - 2;

    // Visibility threshold 0.098, rounded to nearest in the fixed-point format.
    localparam logic signed [CLIP_W-1:0] W_THRESH =
        CLIP_W'(((98 << FRAC_BITS) + 500) / 1000);

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = REG_IDX_W'(1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

    typedef struct packed {
        logic                     op;
        logic [COEFF_IDX_W-1:0]   coeff_index;
        logic signed [DATA_W-1:0] coeff_value;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } t_in_req;

    typedef struct packed {
        logic                     visible;
        logic signed [DATA_W-1:0] screen_x;
        logic signed [DATA_W-1:0] screen_y;
    } t_out_res;

    typedef struct packed {
        logic                     visible;
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cw;
    } t_clip;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_screen_cfg;

endpackage

// ===== rtl/perspective_point_projection.sv =====
// Top level of the perspective point projection block.
// The block projects world points to screen pixels through a 4x4 matrix.
// Requests arrive on the input channel (i_in_valid, o_in_ready, i_in_req).
// A load request (op = 0) writes one matrix coefficient and gives no result;
// a project request (op = 1) gives exactly one result on the output channel
// (o_out_valid, i_out_ready, o_out_res), in request order.
// Throughput is one request per cycle while the receiver does not stall. A
// project request passes the front multiply and sum stages, the queue, then
// the back pipeline of one setup stage, one stage per quotient bit of the
// 40-bit divider, and three stages for NDC, scale and saturation. The divider
// sets the latency. When the receiver stalls, the back pipeline holds and the
// front keeps taking requests until the four-entry queue is full and its
// last stage holds a project request.
// Screen width and height are written through the APB-style port at byte
// addresses 0 and 4; writes should happen while the block is idle.
// Reset clears all coefficients to zero, sets the screen to 1920 by 1080 and
// empties every pipeline stage; no clearing pass is needed.
module perspective_point_projection (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ppp_pkg::t_in_req      i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ppp_pkg::t_out_res     o_out_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ppp_pkg::ADDR_W-1:0] paddr,
    input  logic [ppp_pkg::DATA_W-1:0] pwdata,
    output logic [ppp_pkg::DATA_W-1:0] prdata,
    output logic                  pready
);
    import ppp_pkg::*;

    logic [DIM_W-1:0]     r_width;
    logic [DIM_W-1:0]     r_height;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    t_screen_cfg          screen_cfg;
    t_queue_status        queue_status;
    t_clip                front_clip;
    t_clip                queue_clip;
    logic                 push;
    logic                 pop;

    // The register index is the word address; byte-lane bits are ignored.
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SCREEN_WIDTH: begin
                    r_width <= pwdata[DIM_W-1:0];
                end
                REG_SCREEN_HEIGHT: begin
                    r_height <= pwdata[DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = DATA_W'(r_width);
            REG_SCREEN_HEIGHT: prdata = DATA_W'(r_height);
            default:           prdata = '0;
        endcase
    end

    assign screen_cfg.width  = r_width;
    assign screen_cfg.height = r_height;

    // The front takes every request, applies loads at once and sends the
    // clip values of project requests into the queue.
    ppp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_req       (i_in_req),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_clip         (front_clip)
    );

    ppp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_clip),
        .i_pop    (pop),
        .o_data   (queue_clip),
        .o_status (queue_status)
    );

    // The back divides by clip w and maps the result to the screen.
    ppp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_status (queue_status),
        .i_clip         (queue_clip),
        .o_pop          (pop),
        .i_cfg          (screen_cfg),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_res      (o_out_res)
    );

endmodule

// ===== rtl/ppp_front.sv =====
// Front part: coefficient store, clip products and sums, visibility test.
module ppp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppp_pkg::t_in_req   i_in_req,
    input  ppp_pkg::t_queue_status i_queue_status,
    output logic               o_push,
    output ppp_pkg::t_clip     o_clip
);
    import ppp_pkg::*;

    // Coefficient slot of each clip row (x, y, w) in the first column.
    // The x and y rows sit in slots 0 and 1, the w row skips z and sits in slot 3.
    function automatic int row_slot(input int r);
        return (r == CLIP_ROWS - 1) ? 3 : r;
    endfunction

    logic signed [DATA_W-1:0]   r_coeff [COEFF_COUNT];
    logic signed [2*DATA_W-1:0] r_prod  [CLIP_ROWS][3];
    logic signed [2*DATA_W-1:0] n_prod  [CLIP_ROWS][3];
    logic signed [DATA_W-1:0]   r_bias  [CLIP_ROWS];
    logic signed [DATA_W-1:0]   n_bias  [CLIP_ROWS];
    logic signed [CLIP_W-1:0]   n_sum   [CLIP_ROWS];
    logic signed [DATA_W-1:0]   pos     [3];
    logic                       r_a_valid;
    logic                       r_b_valid;
    t_clip                      r_clip;
    t_clip                      n_clip;
    logic                       en;
    logic                       accept;

    assign en         = !r_b_valid || !i_queue_status.full;
    assign accept     = i_in_valid && en;
    assign o_in_ready = en;
    assign o_push     = r_b_valid && !i_queue_status.full;
    assign o_clip     = r_clip;

    assign pos[0] = i_in_req.pos_x;
    assign pos[1] = i_in_req.pos_y;
    assign pos[2] = i_in_req.pos_z;

    always_comb begin
        for (int r = 0; r < CLIP_ROWS; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[r][k] = pos[k] * r_coeff[row_slot(r) + 4 * k];
            end
            n_bias[r] = r_coeff[row_slot(r) + 12];
        end
    end

    // Products are floored by the arithmetic shift, then summed exactly.
    always_comb begin
        for (int r = 0; r < CLIP_ROWS; r++) begin
            n_sum[r] = CLIP_W'(r_prod[r][0] >>> FRAC_BITS)
                     + CLIP_W'(r_prod[r][1] >>> FRAC_BITS)
                     + CLIP_W'(r_prod[r][2] >>> FRAC_BITS)
                     + CLIP_W'(r_bias[r]);
        end
        n_clip.cx      = n_sum[0];
        n_clip.cy      = n_sum[1];
        n_clip.cw      = n_sum[2];
        n_clip.visible = (n_sum[2] >= W_THRESH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COEFF_COUNT; i++) begin
                r_coeff[i] <= '0;
            end
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept && (i_in_req.op == OP_LOAD)) begin
                r_coeff[i_in_req.coeff_index] <= i_in_req.coeff_value;
            end
            if (en) begin
                r_a_valid <= accept && (i_in_req.op == OP_PROJECT);
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= n_prod;
            r_bias <= n_bias;
            r_clip <= n_clip;
        end
    end

endmodule

// ===== rtl/ppp_queue.sv =====
// Short queue of clip values between the front and back parts.
module ppp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ppp_pkg::t_clip         i_data,
    input  logic                   i_pop,
    output ppp_pkg::t_clip         o_data,
    output ppp_pkg::t_queue_status o_status
);
    import ppp_pkg::*;

    t_clip                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr;
    logic [QUEUE_PTR_W-1:0] r_rptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_status.full  = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("queue read while empty");

    a_count_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[QUEUE_PTR_W-1:0])
        else $error("queue count disagrees with pointers");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on write");

endmodule

// ===== rtl/ppp_back.sv =====
// Back part: pipelined NDC division, screen mapping and saturation.
module ppp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppp_pkg::t_queue_status i_queue_status,
    input  ppp_pkg::t_clip       i_clip,
    output logic                 o_pop,
    input  ppp_pkg::t_screen_cfg i_cfg,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ppp_pkg::t_out_res    o_out_res
);
    import ppp_pkg::*;

    localparam int R_W = CLIP_W;

    typedef struct packed {
        logic [R_W-1:0] rem;
        logic [Q_W-1:0] bits;
        logic [Q_W-1:0] quo;
        logic           neg;
        logic           clamp;
    } t_lane;

    typedef struct packed {
        t_lane          x;
        t_lane          y;
        logic [R_W-1:0] den;
        logic           visible;
    } t_div_stage;

    function automatic t_lane prep_lane(logic signed [CLIP_W-1:0] v, logic [R_W-1:0] den);
        logic [CLIP_W-1:0]           mag;
        logic [CLIP_W+FRAC_BITS-1:0] num;
        t_lane                       o;
        mag     = v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
        num     = {mag, {FRAC_BITS{1'b0}}};
        o.rem   = R_W'(num >> Q_W);
        o.bits  = num[Q_W-1:0];
        o.quo   = '0;
        o.neg   = v[CLIP_W-1];
        o.clamp = ((CLIP_W + INT_W)'(mag) >= {den, {INT_W{1'b0}}});
        return o;
    endfunction

    function automatic t_lane div_step(t_lane l, logic [R_W-1:0] den);
        logic [R_W:0] trial;
        t_lane        o;
        o      = l;
        trial  = {l.rem, l.bits[Q_W-1]};
        o.bits = {l.bits[Q_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
            o.rem = R_W'(trial - {1'b0, den});
            o.quo = {l.quo[Q_W-2:0], 1'b1};
        end else begin
            o.rem = R_W'(trial);
            o.quo = {l.quo[Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic signed [NDC_W-1:0] make_ndc(t_lane l);
        logic [NDC_W-1:0] mag;
        mag = l.clamp ? (NDC_W'(1) << Q_W) : NDC_W'(l.quo);
        return l.neg ? -mag : mag;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(logic signed [SUM_W-1:0] v);
        if ((v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1)) begin
            return v[DATA_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    t_div_stage               r_stg [Q_W+1];
    t_div_stage               n_stg0;
    logic                     r_vld [Q_W+1];
    logic signed [NDC_W-1:0]  r_ndc_x;
    logic signed [NDC_W-1:0]  r_ndc_y;
    logic                     r_m_vis;
    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_mx;
    logic signed [PROD_W-1:0] r_my;
    logic signed [PROD_W-1:0] n_mx;
    logic signed [PROD_W-1:0] n_my;
    logic                     r_p_vis;
    logic                     r_p_valid;
    logic                     r_out_valid;
    t_out_res                 r_out;
    t_out_res                 n_out;
    logic [DIM_W-1:0]         hw;
    logic [DIM_W-1:0]         hh;
    logic signed [K_W-1:0]    kx;
    logic signed [K_W-1:0]    ky;
    logic signed [SUM_W-1:0]  off_x;
    logic signed [SUM_W-1:0]  off_y;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic                     en;

    assign en          = !r_out_valid || i_out_ready;
    assign o_pop       = en && !i_queue_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    assign hw = i_cfg.width >> 1;
    assign hh = i_cfg.height >> 1;

    always_comb begin
        n_stg0.den     = R_W'(i_clip.cw);
        n_stg0.visible = i_clip.visible;
        n_stg0.x       = prep_lane(i_clip.cx, R_W'(i_clip.cw));
        n_stg0.y       = prep_lane(i_clip.cy, R_W'(i_clip.cw));
    end

    // Screen scale factors: (hw + 1) for x and (1 - hh) for y.
    always_comb begin
        kx    = $signed({1'b0, hw}) + K_W'(1);
        ky    = K_W'(1) - $signed({1'b0, hh});
        n_mx  = kx * r_ndc_x;
        n_my  = ky * r_ndc_y;
        off_x = SUM_W'({1'b0, hw, {FRAC_BITS{1'b0}}});
        off_y = SUM_W'({1'b0, hh, {FRAC_BITS{1'b0}}});
        sum_x = SUM_W'(r_mx) + off_x;
        sum_y = SUM_W'(r_my) + off_y;
        n_out.visible  = r_p_vis;
        n_out.screen_x = r_p_vis ? sat32(sum_x) : '0;
        n_out.screen_y = r_p_vis ? sat32(sum_y) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= Q_W; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_m_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= o_pop;
            for (int j = 1; j <= Q_W; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_m_valid   <= r_vld[Q_W];
            r_p_valid   <= r_m_valid;
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_stg[0] <= n_stg0;
            for (int j = 1; j <= Q_W; j++) begin
                r_stg[j].den     <= r_stg[j-1].den;
                r_stg[j].visible <= r_stg[j-1].visible;
                r_stg[j].x       <= div_step(r_stg[j-1].x, r_stg[j-1].den);
                r_stg[j].y       <= div_step(r_stg[j-1].y, r_stg[j-1].den);
            end
            r_ndc_x <= make_ndc(r_stg[Q_W].x);
            r_ndc_y <= make_ndc(r_stg[Q_W].y);
            r_m_vis <= r_stg[Q_W].visible;
            r_mx    <= n_mx;
            r_my    <= n_my;
            r_p_vis <= r_m_vis;
            r_out   <= n_out;
        end
    end

endmodule
